>>> src/axis_angle_rotation_matrix_core_defines.svh
// assertion macros for the checker file of the rotation matrix core
`ifndef AXIS_ANGLE_ROTATION_MATRIX_CORE_DEFINES_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define AARM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define AARM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/aarm_pkg.sv
// shared types, constants and the arctangent table of the rotation matrix core
package aarm_pkg;

  localparam int ANG_W  = 18;
  localparam int AXIS_W = 16;
  localparam int ENT_W  = 16;

  // angle in 1/256 degree
  localparam int DEG_FULL    = 92160;
  localparam int DEG_HALF    = 46080;
  localparam int DEG_QUARTER = 23040;

  // pi/180 in q38, gain and one in q30
  localparam logic [32:0] DEG2RAD_Q46 = 33'd4797524517;
  localparam longint      CORDIC_GAIN = 64'sd652032874;
  localparam longint      ONE_Q30     = 64'sd1073741824;

  localparam int ATAN_MAX = 24;

  // cordic datapath word (q30 with headroom)
  localparam int CW = 33;

  typedef struct packed {
    logic signed [CW-1:0]     x;
    logic signed [CW-1:0]     y;
    logic signed [CW-1:0]     z;
    logic                     neg_c;
    logic                     neg_s;
    logic signed [AXIS_W-1:0] ax;
    logic signed [AXIS_W-1:0] ay;
    logic signed [AXIS_W-1:0] az;
  } cell_t;

  typedef struct packed {
    logic signed [ENT_W-1:0] r00;
    logic signed [ENT_W-1:0] r01;
    logic signed [ENT_W-1:0] r02;
    logic signed [ENT_W-1:0] r10;
    logic signed [ENT_W-1:0] r11;
    logic signed [ENT_W-1:0] r12;
    logic signed [ENT_W-1:0] r20;
    logic signed [ENT_W-1:0] r21;
    logic signed [ENT_W-1:0] r22;
  } mat_t;

  // atan(2^-i) in 2^-30 rad, truncated
  function automatic logic [29:0] atan_entry(input int idx);
    logic [29:0] a;
    unique case (idx)
      0:       a = 30'd843314856;
      1:       a = 30'd497837829;
      2:       a = 30'd263043836;
      3:       a = 30'd133525158;
      4:       a = 30'd67021686;
      5:       a = 30'd33543515;
      6:       a = 30'd16775850;
      7:       a = 30'd8388437;
      8:       a = 30'd4194282;
      9:       a = 30'd2097149;
      10:      a = 30'd1048575;
      11:      a = 30'd524287;
      12:      a = 30'd262143;
      13:      a = 30'd131071;
      14:      a = 30'd65535;
      15:      a = 30'd32767;
      16:      a = 30'd16383;
      17:      a = 30'd8191;
      18:      a = 30'd4095;
      19:      a = 30'd2047;
      20:      a = 30'd1023;
      21:      a = 30'd511;
      22:      a = 30'd255;
      23:      a = 30'd127;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage

>>> src/aarm_in_if.sv
// input channel: angle and axis with valid/ready
interface aarm_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [aarm_pkg::ANG_W-1:0]  angle_deg;
  logic signed [aarm_pkg::AXIS_W-1:0] axis_x;
  logic signed [aarm_pkg::AXIS_W-1:0] axis_y;
  logic signed [aarm_pkg::AXIS_W-1:0] axis_z;

  modport source (output valid, output angle_deg, output axis_x, output axis_y,
                  output axis_z, input ready);
  modport sink   (input valid, input angle_deg, input axis_x, input axis_y,
                  input axis_z, output ready);
endinterface

>>> src/aarm_out_if.sv
// result channel: nine matrix entries with valid/ready
interface aarm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [aarm_pkg::ENT_W-1:0] r00;
  logic signed [aarm_pkg::ENT_W-1:0] r01;
  logic signed [aarm_pkg::ENT_W-1:0] r02;
  logic signed [aarm_pkg::ENT_W-1:0] r10;
  logic signed [aarm_pkg::ENT_W-1:0] r11;
  logic signed [aarm_pkg::ENT_W-1:0] r12;
  logic signed [aarm_pkg::ENT_W-1:0] r20;
  logic signed [aarm_pkg::ENT_W-1:0] r21;
  logic signed [aarm_pkg::ENT_W-1:0] r22;

  modport source (output valid, output r00, output r01, output r02, output r10,
                  output r11, output r12, output r20, output r21, output r22,
                  input ready);
  modport sink   (input valid, input r00, input r01, input r02, input r10,
                  input r11, input r12, input r20, input r21, input r22,
                  output ready);
endinterface

>>> src/aarm_angle_front.sv
// angle front end: fold into +-90 degrees, then convert to radians
module aarm_angle_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [aarm_pkg::ANG_W-1:0]  angle_deg,
  input  logic signed [aarm_pkg::AXIS_W-1:0] axis_x,
  input  logic signed [aarm_pkg::AXIS_W-1:0] axis_y,
  input  logic signed [aarm_pkg::AXIS_W-1:0] axis_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output aarm_pkg::cell_t                    out_data
);

  localparam int AW = aarm_pkg::ANG_W;
  localparam int CW = aarm_pkg::CW;

  logic [1:0] v_r, v_nxt, rdy, dn, up, load;

  // stage 0 payload
  logic [14:0]                        m_r;
  logic                               negc_r, negs_r;
  logic signed [aarm_pkg::AXIS_W-1:0] ax_r, ay_r, az_r;
  // stage 1 payload
  aarm_pkg::cell_t                    cell_r;

  logic signed [20:0]   wrap_s;
  logic [18:0]          wrap_u, mod1, mod2;
  logic signed [AW-1:0] rsig, half_s, fold_s, mag_s;
  logic                 negc, negs;
  logic [47:0]          z_prod, z_rnd;

  assign dn    = {out_ready, rdy[1]};
  assign rdy   = ~v_r | dn;
  assign up    = {v_r[0], in_valid};
  assign load  = up & rdy;
  assign v_nxt = load | (v_r & ~dn);

  assign in_ready  = rdy[0];
  assign out_valid = v_r[1];
  assign out_data  = cell_r;

  always_comb begin
    wrap_s = 21'(angle_deg) + 21'(2 * aarm_pkg::DEG_FULL);
    wrap_u = 19'(wrap_s);
    mod1 = (wrap_u >= 19'(2 * aarm_pkg::DEG_FULL)) ?
           wrap_u - 19'(2 * aarm_pkg::DEG_FULL) : wrap_u;
    mod2 = (mod1 >= 19'(aarm_pkg::DEG_FULL)) ? mod1 - 19'(aarm_pkg::DEG_FULL) : mod1;
    rsig = $signed({1'b0, mod2[16:0]});
    half_s = (mod2 >= 19'(aarm_pkg::DEG_HALF)) ? rsig - AW'(aarm_pkg::DEG_FULL) : rsig;
    negc = 1'b0;
    fold_s = half_s;
    // obtuse angles mirror about +-90 degrees
    if (half_s > AW'(aarm_pkg::DEG_QUARTER)) begin
      fold_s = AW'(aarm_pkg::DEG_HALF) - half_s;
      negc = 1'b1;
    end else if (half_s < -AW'(aarm_pkg::DEG_QUARTER)) begin
      fold_s = -AW'(aarm_pkg::DEG_HALF) - half_s;
      negc = 1'b1;
    end
    negs = fold_s[AW-1];
    mag_s = negs ? -fold_s : fold_s;
  end

  // degrees to radians, rounded, 2^-30 rad units
  assign z_prod = 48'(m_r) * 48'(aarm_pkg::DEG2RAD_Q46);
  assign z_rnd  = z_prod + 48'(32768);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      m_r    <= mag_s[14:0];
      negc_r <= negc;
      negs_r <= negs;
      ax_r   <= axis_x;
      ay_r   <= axis_y;
      az_r   <= axis_z;
    end
    if (load[1]) begin
      cell_r.x     <= CW'(aarm_pkg::CORDIC_GAIN);
      cell_r.y     <= '0;
      cell_r.z     <= $signed({{(CW-32){1'b0}}, z_rnd[47:16]});
      cell_r.neg_c <= negc_r;
      cell_r.neg_s <= negs_r;
      cell_r.ax    <= ax_r;
      cell_r.ay    <= ay_r;
      cell_r.az    <= az_r;
    end
  end

endmodule

>>> src/aarm_cordic_cell.sv
// one rotation-mode cordic iteration as a registered cell
module aarm_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  aarm_pkg::cell_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output aarm_pkg::cell_t out_data
);

  localparam int CW = aarm_pkg::CW;
  localparam logic signed [CW-1:0] ATAN_I =
    $signed({{(CW-30){1'b0}}, aarm_pkg::atan_entry(STEP)});

  logic            v_r, v_nxt, load;
  aarm_pkg::cell_t d_r, d_nxt;
  logic signed [CW-1:0] dx, dy;

  assign in_ready  = !v_r || out_ready;
  assign load      = in_valid && in_ready;
  assign v_nxt     = load || (v_r && !out_ready);
  assign out_valid = v_r;
  assign out_data  = d_r;

  always_comb begin
    dx = in_data.y >>> STEP;
    dy = in_data.x >>> STEP;
    d_nxt = in_data;
    if (!in_data.z[CW-1]) begin
      d_nxt.x = in_data.x - dx;
      d_nxt.y = in_data.y + dy;
      d_nxt.z = in_data.z - ATAN_I;
    end else begin
      d_nxt.x = in_data.x + dx;
      d_nxt.y = in_data.y - dy;
      d_nxt.z = in_data.z + ATAN_I;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      d_r <= d_nxt;
    end
  end

endmodule

>>> src/aarm_matrix_back.sv
// matrix back end: sign fix, products, sums, rounding and saturation
module aarm_matrix_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  aarm_pkg::cell_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output aarm_pkg::mat_t  out_data
);

  localparam int CW  = aarm_pkg::CW;
  localparam int XW  = aarm_pkg::AXIS_W;
  localparam int EW  = aarm_pkg::ENT_W;
  localparam int TW  = CW + 1;          // 1 - c
  localparam int PW  = 2 * XW;          // axis products
  localparam int LOW = 17;              // low slice of t
  localparam int LW  = LOW + 1 + PW;    // low partial
  localparam int HW  = TW - LOW + PW;   // high partial
  localparam int SAW = CW + XW;         // s * a
  localparam int SW  = 68;              // q58 sums
  localparam int QW  = SW - 44;
  localparam logic signed [SW-1:0] RND = $signed({{(SW-44){1'b0}}, 1'b1, 43'b0});

  logic [3:0] v_r, v_nxt, rdy, dn, up, load;

  // stage 0
  logic signed [CW-1:0] c0_r, s0_r;
  logic signed [TW-1:0] t0_r;
  logic signed [PW-1:0] pxx_r, pyy_r, pzz_r, pxy_r, pxz_r, pyz_r;
  logic signed [XW-1:0] ax_r, ay_r, az_r;
  // stage 1
  logic signed [CW-1:0]  c1_r;
  logic signed [LW-1:0]  lxx_r, lyy_r, lzz_r, lxy_r, lxz_r, lyz_r;
  logic signed [HW-1:0]  hxx_r, hyy_r, hzz_r, hxy_r, hxz_r, hyz_r;
  logic signed [SAW-1:0] sax_r, say_r, saz_r;
  // stage 2
  logic signed [SW-1:0] cd_r, txx_r, tyy_r, tzz_r, txy_r, txz_r, tyz_r;
  logic signed [SW-1:0] sqx_r, sqy_r, sqz_r;
  // stage 3
  aarm_pkg::mat_t       mat_r;

  logic signed [CW-1:0]    c0, s0;
  logic signed [LOW:0]     t_lo;
  logic signed [TW-LOW-1:0] t_hi;

  function automatic logic signed [EW-1:0] sat_entry(input logic signed [SW-1:0] v);
    logic signed [QW-1:0] q;
    logic signed [EW-1:0] r;
    q = v[SW-1:44];
    if (q > QW'(32767)) begin
      r = EW'(32767);
    end else if (q < -QW'(32768)) begin
      r = -EW'(32768);
    end else begin
      r = q[EW-1:0];
    end
    return r;
  endfunction

  assign dn    = {out_ready, rdy[3:1]};
  assign rdy   = ~v_r | dn;
  assign up    = {v_r[2:0], in_valid};
  assign load  = up & rdy;
  assign v_nxt = load | (v_r & ~dn);

  assign in_ready  = rdy[0];
  assign out_valid = v_r[3];
  assign out_data  = mat_r;

  assign c0   = in_data.neg_c ? -in_data.x : in_data.x;
  assign s0   = in_data.neg_s ? -in_data.y : in_data.y;
  assign t_lo = $signed({1'b0, t0_r[LOW-1:0]});
  assign t_hi = t0_r[TW-1:LOW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      c0_r  <= c0;
      s0_r  <= s0;
      t0_r  <= TW'(aarm_pkg::ONE_Q30) - TW'(c0);
      pxx_r <= PW'(in_data.ax) * PW'(in_data.ax);
      pyy_r <= PW'(in_data.ay) * PW'(in_data.ay);
      pzz_r <= PW'(in_data.az) * PW'(in_data.az);
      pxy_r <= PW'(in_data.ax) * PW'(in_data.ay);
      pxz_r <= PW'(in_data.ax) * PW'(in_data.az);
      pyz_r <= PW'(in_data.ay) * PW'(in_data.az);
      ax_r  <= in_data.ax;
      ay_r  <= in_data.ay;
      az_r  <= in_data.az;
    end
    // t times axis product split in two partials
    if (load[1]) begin
      c1_r  <= c0_r;
      lxx_r <= LW'(t_lo) * LW'(pxx_r);
      lyy_r <= LW'(t_lo) * LW'(pyy_r);
      lzz_r <= LW'(t_lo) * LW'(pzz_r);
      lxy_r <= LW'(t_lo) * LW'(pxy_r);
      lxz_r <= LW'(t_lo) * LW'(pxz_r);
      lyz_r <= LW'(t_lo) * LW'(pyz_r);
      hxx_r <= HW'(t_hi) * HW'(pxx_r);
      hyy_r <= HW'(t_hi) * HW'(pyy_r);
      hzz_r <= HW'(t_hi) * HW'(pzz_r);
      hxy_r <= HW'(t_hi) * HW'(pxy_r);
      hxz_r <= HW'(t_hi) * HW'(pxz_r);
      hyz_r <= HW'(t_hi) * HW'(pyz_r);
      sax_r <= SAW'(s0_r) * SAW'(ax_r);
      say_r <= SAW'(s0_r) * SAW'(ay_r);
      saz_r <= SAW'(s0_r) * SAW'(az_r);
    end
    // rounding offset rides on c for the diagonal and on t*a*b off it
    if (load[2]) begin
      cd_r  <= (SW'(c1_r) <<< 28) + RND;
      txx_r <= (SW'(hxx_r) <<< LOW) + SW'(lxx_r);
      tyy_r <= (SW'(hyy_r) <<< LOW) + SW'(lyy_r);
      tzz_r <= (SW'(hzz_r) <<< LOW) + SW'(lzz_r);
      txy_r <= (SW'(hxy_r) <<< LOW) + SW'(lxy_r) + RND;
      txz_r <= (SW'(hxz_r) <<< LOW) + SW'(lxz_r) + RND;
      tyz_r <= (SW'(hyz_r) <<< LOW) + SW'(lyz_r) + RND;
      sqx_r <= SW'(sax_r) <<< 14;
      sqy_r <= SW'(say_r) <<< 14;
      sqz_r <= SW'(saz_r) <<< 14;
    end
    if (load[3]) begin
      mat_r.r00 <= sat_entry(cd_r + txx_r);
      mat_r.r01 <= sat_entry(txy_r - sqz_r);
      mat_r.r02 <= sat_entry(txz_r + sqy_r);
      mat_r.r10 <= sat_entry(txy_r + sqz_r);
      mat_r.r11 <= sat_entry(cd_r + tyy_r);
      mat_r.r12 <= sat_entry(tyz_r - sqx_r);
      mat_r.r20 <= sat_entry(txz_r - sqy_r);
      mat_r.r21 <= sat_entry(tyz_r + sqx_r);
      mat_r.r22 <= sat_entry(cd_r + tzz_r);
    end
  end

endmodule

>>> src/axis_angle_rotation_matrix_core.sv
// top level of the axis-angle (rodrigues) rotation matrix core
//
// usage
//   in_ch  : one transfer carries an angle in degrees (8 fraction bits) and a
//            q2.14 unit axis; out_ch : one transfer carries the nine entries
//            of R in row-major order as saturated q2.14
//   both channels transfer when valid and ready are high at a rising clk edge
//   pipeline: 2 front-end stages (angle fold, radian conversion), one cordic
//            cell per step, 4 product stages
//   throughput: one item per cycle while out_ch.ready is high; every stage
//            is a register with its own valid, so the chain keeps filling
//            bubbles while out_ch stalls
//   stall: a result held at out_ch stays stable; in_ch.ready drops only once
//          every stage holds an item
//   reset: rst_n low at a rising clk edge empties all stages; no clearing pass,
//          the block takes input on the first cycle after reset
module axis_angle_rotation_matrix_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  aarm_in_if.sink           in_ch,
  aarm_out_if.source        out_ch
);

  // the arctangent table stops at 24 entries
  localparam int STEPS = (CORDIC_STEPS > aarm_pkg::ATAN_MAX) ?
                         aarm_pkg::ATAN_MAX : CORDIC_STEPS;

  // cell chain handshake and data, index 0 is the front end output
  logic [STEPS:0]  cv;
  logic [STEPS:0]  cr;
  aarm_pkg::cell_t cdat [STEPS+1];
  aarm_pkg::mat_t  mat;

  // fold and radian conversion
  aarm_angle_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .angle_deg (in_ch.angle_deg),
    .axis_x    (in_ch.axis_x),
    .axis_y    (in_ch.axis_y),
    .axis_z    (in_ch.axis_z),
    .out_valid (cv[0]),
    .out_ready (cr[0]),
    .out_data  (cdat[0])
  );

  // one cordic iteration per cell, axis and sign flags ride along
  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    aarm_cordic_cell #(
      .STEP (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (cv[i]),
      .in_ready  (cr[i]),
      .in_data   (cdat[i]),
      .out_valid (cv[i+1]),
      .out_ready (cr[i+1]),
      .out_data  (cdat[i+1])
    );
  end

  // c, s, 1-c times the axis outer product, sums, round and saturate
  aarm_matrix_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cv[STEPS]),
    .in_ready  (cr[STEPS]),
    .in_data   (cdat[STEPS]),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (mat)
  );

  // row-major entries onto the result channel
  assign out_ch.r00 = mat.r00;
  assign out_ch.r01 = mat.r01;
  assign out_ch.r02 = mat.r02;
  assign out_ch.r10 = mat.r10;
  assign out_ch.r11 = mat.r11;
  assign out_ch.r12 = mat.r12;
  assign out_ch.r20 = mat.r20;
  assign out_ch.r21 = mat.r21;
  assign out_ch.r22 = mat.r22;

endmodule

>>> src/aarm_checker.sv
// port-level checker for the rotation matrix core and its bind
`include "axis_angle_rotation_matrix_core_defines.svh"

module aarm_checker #(
  parameter int DEPTH = 22
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [9*aarm_pkg::ENT_W-1:0]  out_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic             in_xfer, out_xfer;
  logic [CNT_W-1:0] occ_r, occ_nxt;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign occ_nxt  = occ_r + CNT_W'(in_xfer) - CNT_W'(out_xfer);

  // items inside the core
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  `AARM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
  `AARM_ASSERT_NOW(a_out_has_item, out_valid, occ_r != '0, "result shown with no item inside")
  `AARM_ASSERT_NOW(a_occ_bound, 1'b1, occ_r <= CNT_W'(DEPTH), "more items inside than stages")
  `AARM_ASSERT_NOW(a_empty_ready, occ_r == '0, in_ready, "empty core refused an input")

endmodule

bind axis_angle_rotation_matrix_core aarm_checker #(
  .DEPTH (STEPS + 6)
) u_aarm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  ({out_ch.r00, out_ch.r01, out_ch.r02, out_ch.r10, out_ch.r11,
               out_ch.r12, out_ch.r20, out_ch.r21, out_ch.r22})
);

>>> bench/axis_angle_rotation_matrix_core_test.sv
// self-checking testbench of the axis-angle rotation matrix core
module axis_angle_rotation_matrix_core_test;
  typedef aarm_pkg::mat_t mat_t;
  localparam int ANG_W  = aarm_pkg::ANG_W;
  localparam int AXIS_W = aarm_pkg::AXIS_W;
  localparam int ENT_W  = aarm_pkg::ENT_W;

  // cordic length under test and the pipeline depth it implies
  localparam int STEPS       = 16;
  localparam int TABLE_STEPS = (STEPS > 24) ? 24 : STEPS;
  localparam int LATENCY     = STEPS + 6;

  // angle units of 1/256 degree, radian factor in q38, cordic constants in q30
  localparam longint FULL_TURN = 92160;
  localparam longint HALF_TURN = 46080;
  localparam longint QUARTER   = 23040;
  localparam longint RAD_Q46   = 64'sd4797524517;
  localparam longint GAIN_Q30  = 64'sd652032874;
  localparam longint UNIT_Q30  = 64'sd1073741824;

  // atan(2^-i) in 2^-30 rad, truncated
  localparam longint ARCTAN [24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127
  };

  // run shape
  localparam int RANDOM_ITEMS = 600;
  localparam int STEADY_FROM  = 300;
  localparam int STEADY_TO    = 450;
  localparam int DRAIN_AT     = 450;
  localparam int HOLD_AT      = 100;
  localparam int HOLD_CYCLES  = 80;
  localparam int IDLE_PCT     = 14;
  localparam int STALL_LIMIT  = 4000;

  // matrices that can be read straight off the formula
  localparam mat_t UNIT_DIAG  = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
  localparam mat_t FLIP_DIAG  = '{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384};
  localparam mat_t ALL_HIGH   = '{32767, 32767, 32767, 32767, 32767, 32767,
                                  32767, 32767, 32767};
  localparam mat_t CHECKER    = '{32767, -32768, 32767, -32768, 32767, -32768,
                                  32767, -32768, 32767};
  localparam mat_t NO_PRESET  = '0;

  typedef struct packed {
    logic signed [ANG_W-1:0]  angle;
    logic signed [AXIS_W-1:0] ax;
    logic signed [AXIS_W-1:0] ay;
    logic signed [AXIS_W-1:0] az;
    logic                     preset;
    mat_t                     matrix;
  } plan_row_t;

  // directed part: angle folding edges, turn wrap, 18-bit extremes,
  // null and oversized axes, saturation in both directions
  localparam int PLAN_ROWS = 23;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{0,       0,      0,      0,      1'b1, UNIT_DIAG},  // zero angle, null axis
    '{92160,   0,      0,      0,      1'b1, UNIT_DIAG},  // full turn wraps to zero
    '{-92160,  0,      0,      0,      1'b1, UNIT_DIAG},
    '{46080,   0,      0,      0,      1'b1, FLIP_DIAG},  // half turn flips cosine
    '{-46080,  0,      0,      0,      1'b1, FLIP_DIAG},
    '{46080,  -32768, -32768, -32768,  1'b1, ALL_HIGH},   // oversized axis saturates
    '{46080,   32767, -32768,  32767,  1'b1, CHECKER},    // both saturation rails
    '{23040,   16384,  0,      0,      1'b0, NO_PRESET},  // right angle, no fold
    '{-23040,  0,      16384,  0,      1'b0, NO_PRESET},
    '{23041,   0,      0,      16384,  1'b0, NO_PRESET},  // just past right angle
    '{-23041,  0,      0,     -16384,  1'b0, NO_PRESET},
    '{11520,  -16384,  0,      0,      1'b0, NO_PRESET},
    '{46079,   0,     -16384,  0,      1'b0, NO_PRESET},  // last code below half turn
    '{69120,   9459,   9459,   9459,   1'b0, NO_PRESET},
    '{-69120, -9459,  -9459,  -9459,   1'b0, NO_PRESET},
    '{131071,  16384,  16384,  16384,  1'b0, NO_PRESET},  // widest positive code
    '{-131072, 0,      0,      16384,  1'b0, NO_PRESET},  // widest negative code
    '{92159,   16384,  0,      0,      1'b0, NO_PRESET},
    '{-92159,  0,      16384,  0,      1'b0, NO_PRESET},
    '{7680,    8192,  -14189,  0,      1'b0, NO_PRESET},
    '{256,    -32768,  0,      0,      1'b0, NO_PRESET},
    '{1,       0,      16384,  0,      1'b0, NO_PRESET},
    '{-1,      32767,  32767,  32767,  1'b0, NO_PRESET}
  };

  logic clk;
  logic rst_n = 1'b0;

  aarm_in_if  in_ch ();
  aarm_out_if out_ch ();

  axis_angle_rotation_matrix_core #(.CORDIC_STEPS(STEPS)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // matrices owed for accepted inputs, oldest first
  mat_t  pending_matrices [$];
  int    mismatches   = 0;
  int    results_seen = 0;
  bit    steady       = 1'b0;
  string entry_name [9] = '{"r00", "r01", "r02", "r10", "r11", "r12", "r20", "r21", "r22"};

  // q58 sum to q14: round half up, then clamp to the 16-bit range
  function automatic logic signed [ENT_W-1:0] to_q14(input longint q58);
    longint r;
    r = (q58 + (64'sd1 <<< 43)) >>> 44;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[ENT_W-1:0];
  endfunction

  // rodrigues matrix from angle and axis, bit exact to the fixed-point datapath
  function automatic mat_t rodrigues_matrix(input logic signed [ANG_W-1:0]  angle,
                                            input logic signed [AXIS_W-1:0] ax_in,
                                            input logic signed [AXIS_W-1:0] ay_in,
                                            input logic signed [AXIS_W-1:0] az_in);
    longint r, mag, x, y, z, dx, dy, c, s, t;
    longint ax, ay, az, cd, sx, sy, sz, txy, txz, tyz;
    bit     flip_c, flip_s;
    mat_t   m;
    // wrap to one turn, then into [-180, 180)
    r = (longint'(angle) + 2 * FULL_TURN) % FULL_TURN;
    if (r >= HALF_TURN) r = r - FULL_TURN;
    // mirror obtuse angles about +-90 degrees, cosine changes sign
    flip_c = 1'b0;
    if (r > QUARTER) begin
      r = HALF_TURN - r;
      flip_c = 1'b1;
    end else if (r < -QUARTER) begin
      r = -HALF_TURN - r;
      flip_c = 1'b1;
    end
    flip_s = (r < 0);
    mag    = flip_s ? -r : r;
    // degrees to 2^-30 rad, rounded
    z = (mag * RAD_Q46 + 32768) >>> 16;
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < TABLE_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ARCTAN[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ARCTAN[i];
      end
    end
    c  = flip_c ? -x : x;
    s  = flip_s ? -y : y;
    t  = UNIT_Q30 - c;
    ax = longint'(ax_in);
    ay = longint'(ay_in);
    az = longint'(az_in);
    cd  = c * 268435456;
    sx  = s * ax * 16384;
    sy  = s * ay * 16384;
    sz  = s * az * 16384;
    txy = t * (ax * ay);
    txz = t * (ax * az);
    tyz = t * (ay * az);
    m.r00 = to_q14(cd + t * (ax * ax));
    m.r01 = to_q14(txy - sz);
    m.r02 = to_q14(txz + sy);
    m.r10 = to_q14(txy + sz);
    m.r11 = to_q14(cd + t * (ay * ay));
    m.r12 = to_q14(tyz - sx);
    m.r20 = to_q14(txz - sy);
    m.r21 = to_q14(tyz + sx);
    m.r22 = to_q14(cd + t * (az * az));
    return m;
  endfunction

  // 4-unit clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // one input transfer: random idle gaps first unless steady, then hold valid until ready
  task automatic offer(input logic signed [ANG_W-1:0]  angle,
                       input logic signed [AXIS_W-1:0] ax,
                       input logic signed [AXIS_W-1:0] ay,
                       input logic signed [AXIS_W-1:0] az,
                       input mat_t                     owed);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid     <= 1'b1;
    in_ch.angle_deg <= angle;
    in_ch.axis_x    <= ax;
    in_ch.axis_y    <= ay;
    in_ch.axis_z    <= az;
    do @(posedge clk); while (!in_ch.ready);
    pending_matrices.push_back(owed);
  endtask

  // input side: reset, directed table, then random items
  initial begin : input_side
    logic signed [ANG_W-1:0]  angle;
    logic signed [AXIS_W-1:0] ax, ay, az;
    int                       pick;
    in_ch.valid     <= 1'b0;
    in_ch.angle_deg <= '0;
    in_ch.axis_x    <= '0;
    in_ch.axis_y    <= '0;
    in_ch.axis_z    <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; preset rows carry their matrix, the rest use the predictor
    for (int row = 0; row < PLAN_ROWS; row++) begin
      offer(PLAN[row].angle, PLAN[row].ax, PLAN[row].ay, PLAN[row].az,
            PLAN[row].preset ? PLAN[row].matrix
                             : rodrigues_matrix(PLAN[row].angle, PLAN[row].ax,
                                                PLAN[row].ay, PLAN[row].az));
    end

    for (int item = 0; item < RANDOM_ITEMS; item++) begin
      steady = (item >= STEADY_FROM) && (item < STEADY_TO);
      // sender goes quiet until every owed matrix has come back
      if (item == DRAIN_AT) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_matrices.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(99);
      if (pick < 10) begin
        // raw codes: any 18-bit angle, any 16-bit axis
        angle = ANG_W'($urandom);
        ax    = AXIS_W'($urandom);
        ay    = AXIS_W'($urandom);
        az    = AXIS_W'($urandom);
      end else begin
        angle = ANG_W'($urandom_range(2 * FULL_TURN) - FULL_TURN);
        if (pick < 30) begin
          // axis along one coordinate, either direction
          ax = 0;
          ay = 0;
          az = 0;
          case ($urandom_range(2))
            0:       ax = AXIS_W'($urandom_range(1) ? 16384 : -16384);
            1:       ay = AXIS_W'($urandom_range(1) ? 16384 : -16384);
            default: az = AXIS_W'($urandom_range(1) ? 16384 : -16384);
          endcase
        end else begin
          ax = AXIS_W'($urandom_range(32768) - 16384);
          ay = AXIS_W'($urandom_range(32768) - 16384);
          az = AXIS_W'($urandom_range(32768) - 16384);
        end
      end
      offer(angle, ax, ay, az, rodrigues_matrix(angle, ax, ay, az));
    end
    in_ch.valid <= 1'b0;
    steady = 1'b0;

    // drain, then allow the pipeline depth for stray transfers
    while (pending_matrices.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // compare one result transfer against the oldest owed matrix
  task automatic check_result();
    mat_t got, owed;
    got = {out_ch.r00, out_ch.r01, out_ch.r02, out_ch.r10, out_ch.r11,
           out_ch.r12, out_ch.r20, out_ch.r21, out_ch.r22};
    results_seen++;
    if (pending_matrices.size() == 0) begin
      mismatches++;
      $display("%0t: result with no pending input, expected none, actual %h", $time, got);
      return;
    end
    owed = pending_matrices.pop_front();
    for (int k = 0; k < 9; k++) begin
      if (got[(8-k)*ENT_W +: ENT_W] !== owed[(8-k)*ENT_W +: ENT_W]) begin
        mismatches++;
        $display("%0t: %s expected %0d actual %0d", $time, entry_name[k],
                 $signed(owed[(8-k)*ENT_W +: ENT_W]), $signed(got[(8-k)*ENT_W +: ENT_W]));
      end
    end
  endtask

  // result side: random back-pressure, one long hold-off to fill the pipeline
  initial begin : result_side
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) check_result();
      if (!held && results_seen == HOLD_AT) begin
        // long stall so the input side backs up and ready drops
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // watchdog: too many cycles without any transfer ends the run
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule

>>> filelist.f
+incdir+src
src/aarm_pkg.sv
src/aarm_in_if.sv
src/aarm_out_if.sv
src/aarm_angle_front.sv
src/aarm_cordic_cell.sv
src/aarm_matrix_back.sv
src/axis_angle_rotation_matrix_core.sv
src/aarm_checker.sv
bench/axis_angle_rotation_matrix_core_test.sv
